[design/mpf_pkg.sv]
// mpf_pkg: transfer payload types, action and channel codes, popcount helper
// for the masked popcount fitness scorer. No dependencies.
package mpf_pkg;

    localparam int ChanCount = 3;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCORE = 1'b1;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;   // names no channel

    typedef logic [5:0] t_count;   // 0..32
    typedef logic [6:0] t_sum;     // 0..96

    typedef struct packed {
        logic        action;
        logic [7:0]  mask_level;
        logic [1:0]  mask_channel;
        logic [31:0] mask_value;
        logic [31:0] genome_word;
        logic [7:0]  env_red;
        logic [7:0]  env_green;
        logic [7:0]  env_blue;
        logic        last_word;
    } t_in;

    typedef struct packed {
        logic [15:0] fitness;
        logic [15:0] distance;
    } t_out;

    // set-bit count of a 32-bit word, folded as a tree
    function automatic t_count f_popcount(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [7:0]  d;
        a = v - ((v >> 1) & 32'h5555_5555);
        b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
        c = (b + (b >> 4)) & 32'h0F0F_0F0F;
        d = c[7:0] + c[15:8] + c[23:16] + c[31:24];
        return d[5:0];
    endfunction

endpackage

[design/masked_popcount_fitness.sv]
// masked_popcount_fitness: banked mask store, XOR/popcount pipeline and
// saturating fitness accumulator. Depends on mpf_pkg.
//
//  channel   signals                          transfer when
//  -------   -------------------------------  ---------------------------
//  input     i_in_valid/o_in_ready/i_in_data  valid & ready at clock edge
//  output    o_out_valid/i_out_ready/o_out_data  valid & ready at clock edge
//  config    i_cfg_we/i_cfg_data (target)     write enable at clock edge
//
// One item per cycle while no held result stalls the pipeline; a result is
// valid after the last word's transfer has passed the mask read at the
// transfer edge, then popcount, accumulate and distance/output register.
// The rate is set by the three single-port mask banks, one read each a cycle.
// Reset (synchronous, active low) clears stage valids, the running total and
// the target; the mask banks hold no reset and need no clearing pass.
// A held result stalls the whole pipeline, so ready drops only while the
// output register is full and not being taken.
module masked_popcount_fitness
    import mpf_pkg::*;
#(
    parameter int MASK_LEVELS = 256,
    parameter int TOTAL_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int AddrW = (MASK_LEVELS > 1) ? $clog2(MASK_LEVELS) : 1;
    localparam logic [8:0] LevelLim = 9'(MASK_LEVELS);
    localparam logic [TOTAL_WIDTH-1:0] TotalMax = '1;

    // pipeline advance: everything moves unless a result sits untaken
    logic w_adv;
    logic w_acc;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_acc      = i_in_valid && w_adv;

    // target register
    logic [15:0] r_target;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    // ---- stage 0: bank write or read issue ----
    logic             w_is_score;
    logic             w_wr_ok;
    logic [AddrW-1:0] w_wr_addr;
    logic [7:0]       w_env    [ChanCount];
    logic [ChanCount-1:0] w_lvl_ok;
    logic [31:0]      w_rd     [ChanCount];

    assign w_is_score = (i_in_data.action == ACT_SCORE);
    // writes beyond the table or to the unused channel code are dropped
    assign w_wr_ok    = ({1'b0, i_in_data.mask_level} < LevelLim) &&
                        (i_in_data.mask_channel != CH_NONE);
    assign w_wr_addr  = i_in_data.mask_level[AddrW-1:0];
    assign w_env[0]   = i_in_data.env_red;
    assign w_env[1]   = i_in_data.env_green;
    assign w_env[2]   = i_in_data.env_blue;

    for (genvar g = 0; g < ChanCount; g++) begin : g_bank
        logic [31:0] r_mem [MASK_LEVELS];
        logic [31:0] r_rd;
        logic        w_we;
        logic        w_re;

        assign w_lvl_ok[g] = ({1'b0, w_env[g]} < LevelLim);
        assign w_we = w_acc && !w_is_score && w_wr_ok &&
                      (i_in_data.mask_channel == 2'(g));
        assign w_re = w_acc && w_is_score;

        // a write and a read never share an edge (one item per edge), and a
        // read on any later edge sees the new word, so no forwarding is needed
        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wr_addr] <= i_in_data.mask_value;
            end
            if (w_re) begin
                r_rd <= r_mem[w_env[g][AddrW-1:0]];
            end
        end
        assign w_rd[g] = r_rd;
    end

    // ---- stage 1: masks read; XOR and popcount ----
    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic [31:0]          r_s1_word;
    logic [ChanCount-1:0] r_s1_lvl_ok;
    t_count               n_cnt [ChanCount];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid && w_is_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_last   <= i_in_data.last_word;
            r_s1_word   <= i_in_data.genome_word;
            r_s1_lvl_ok <= w_lvl_ok;
        end
    end

    always_comb begin
        for (int c = 0; c < ChanCount; c++) begin
            // level beyond the table: mask of zero, word counted as is
            n_cnt[c] = f_popcount((r_s1_lvl_ok[c] ? w_rd[c] : 32'h0) ^ r_s1_word);
        end
    end

    // ---- stage 2: sum counts, saturating accumulate ----
    logic                   r_s2_valid;
    logic                   r_s2_last;
    t_count                 r_s2_cnt [ChanCount];
    logic [TOTAL_WIDTH-1:0] r_total;
    t_sum                   w_sum;
    logic [TOTAL_WIDTH:0]   w_tot_ext;
    logic [TOTAL_WIDTH-1:0] n_total_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_last <= r_s1_last;
            for (int c = 0; c < ChanCount; c++) begin
                r_s2_cnt[c] <= n_cnt[c];
            end
        end
    end

    assign w_sum       = t_sum'(r_s2_cnt[0]) + t_sum'(r_s2_cnt[1]) + t_sum'(r_s2_cnt[2]);
    assign w_tot_ext   = {1'b0, r_total} + (TOTAL_WIDTH+1)'(w_sum);
    // sum is far below the total range, so a carry out means overflow
    assign n_total_sat = w_tot_ext[TOTAL_WIDTH] ? TotalMax : w_tot_ext[TOTAL_WIDTH-1:0];

    // ---- stage 3: fitness held for the distance / output register ----
    logic        r_s3_valid;
    logic [15:0] r_s3_fit;
    logic [TOTAL_WIDTH+15:0] w_fit_ext;

    assign w_fit_ext = {16'h0, n_total_sat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_total <= r_s2_last ? '0 : n_total_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid && r_s2_last) begin
            r_s3_fit <= w_fit_ext[15:0];
        end
    end

    // ---- output register: absolute distance from target ----
    logic [16:0] w_diff;
    logic [15:0] n_dist;
    logic        r_out_valid;
    t_out        r_out;

    assign w_diff = {1'b0, r_target} - {1'b0, r_s3_fit};
    assign n_dist = w_diff[16] ? (r_s3_fit - r_target) : w_diff[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_out.fitness  <= r_s3_fit;
            r_out.distance <= n_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    a_write_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_score) |=> !r_s1_valid)
        else $error("mask write entered the scoring pipeline");

    a_total_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_valid && r_s2_last) |=> (r_total == '0) && r_s3_valid)
        else $error("last word did not clear total or raise a result");

    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_total))
        else $error("running total moved during a stall");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_s3_valid)))
        else $error("pipeline advanced under a held result");

endmodule

[tb/sv/tb.sv]
// tb: self-checking testbench for masked_popcount_fitness, with a scoreboard class holding
// its own mask table, running total and target. Depends on mpf_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import mpf_pkg::*;

    localparam int          MaskLevels  = 256;
    localparam int unsigned TotalMax    = 65535;  // saturation point of the 16-bit total
    localparam int          DrainCycles = 12;     // covers the result latency, plus margin
    localparam int          HoldCycles  = 60;     // long receiver hold-off
    localparam int          StallLimit  = 2000;   // cycles without any transfer
    localparam int          ErrorCap    = 50;     // stop reporting after this many mismatches

    // Scoreboard: shadow mask table and total. Expected fitness/distance pairs
    // are queued as score transfers with the last mark are accepted.
    class fitness_scoreboard;
        logic [31:0] masks [MaskLevels * ChanCount];
        int unsigned genome_total;
        logic [15:0] target;
        t_out        expected_scores [$];
        int          fail_count;

        function new();
            genome_total = 0;
            target       = '0;
            fail_count   = 0;
        endfunction

        function void absorb_item(input t_in d);
            int unsigned bits;
            t_out        want;
            if (d.action == ACT_WRITE) begin
                if (d.mask_channel != CH_NONE)
                    masks[int'(d.mask_level) * ChanCount + int'(d.mask_channel)] = d.mask_value;
                return;
            end
            bits = $countones(d.genome_word ^ masks[int'(d.env_red) * ChanCount + CH_RED])
                 + $countones(d.genome_word ^ masks[int'(d.env_green) * ChanCount + CH_GREEN])
                 + $countones(d.genome_word ^ masks[int'(d.env_blue) * ChanCount + CH_BLUE]);
            genome_total = genome_total + bits;
            if (genome_total > TotalMax)
                genome_total = TotalMax;
            if (d.last_word) begin
                want.fitness  = genome_total[15:0];
                want.distance = (target >= want.fitness) ? target - want.fitness
                                                         : want.fitness - target;
                expected_scores.push_back(want);
                genome_total = 0;
            end
        endfunction

        function void check_score(input t_out got);
            t_out want;
            if (expected_scores.size() == 0) begin
                if (fail_count < ErrorCap)
                    $error("result with nothing expected: fitness %0d, distance %0d",
                           got.fitness, got.distance);
                fail_count++;
                return;
            end
            want = expected_scores.pop_front();
            if (got.fitness !== want.fitness) begin
                if (fail_count < ErrorCap)
                    $error("fitness: expected %0d, got %0d", want.fitness, got.fitness);
                fail_count++;
            end
            if (got.distance !== want.distance) begin
                if (fail_count < ErrorCap)
                    $error("distance: expected %0d, got %0d", want.distance, got.distance);
                fail_count++;
            end
        endfunction
    endclass

    // Block ports, inputs driven to known values from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = '0;

    fitness_scoreboard sb;

    bit          quiet       = 1'b0;   // no idling in the closing phase
    logic        hold_req    = 1'b0;   // asks the receiver for a long hold-off
    int          stall_cycles = 0;

    // Levels written so far per channel; scoring only ever selects these.
    bit          is_written [ChanCount][MaskLevels];
    logic [7:0]  written_lv [ChanCount][$];

    masked_popcount_fitness #(
        .MASK_LEVELS (MaskLevels),
        .TOTAL_WIDTH (16)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: note every input transfer in the scoreboard, check every result.
    // Sampled at the edge, before any of this step's nonblocking updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.absorb_item(i_in_data);
            if (o_out_valid && i_out_ready)
                sb.check_score(o_out_data);
        end
    end

    // Watchdog: a run that stops moving has hung somewhere.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: mostly ready, with random stalls and one long
    // hold-off on request so the pipeline backs up into the input side.
    initial begin : result_sink
        int n;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge i_clk);
                hold_req <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until the transfer; sometimes idle after it.
    // Returns on the transfer edge with valid still high, or after the idle gap with valid low.
    task automatic send_item(input t_in d);
        int gap;
        i_in_data  <= d;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Fields the block ignores for a given action still carry random bits.
    function automatic t_in random_fill();
        t_in d;
        d.action       = ACT_SCORE;
        d.mask_level   = 8'($urandom);
        d.mask_channel = 2'($urandom);
        d.mask_value   = $urandom;
        d.genome_word  = $urandom;
        d.env_red      = 8'($urandom);
        d.env_green    = 8'($urandom);
        d.env_blue     = 8'($urandom);
        d.last_word    = 1'($urandom);
        return d;
    endfunction

    task automatic send_write(input logic [7:0] lvl, input logic [1:0] ch,
                              input logic [31:0] val, input logic last);
        t_in d;
        d              = random_fill();
        d.action       = ACT_WRITE;
        d.mask_level   = lvl;
        d.mask_channel = ch;
        d.mask_value   = val;
        d.last_word    = last;
        if (ch != CH_NONE && !is_written[ch][lvl]) begin
            is_written[ch][lvl] = 1'b1;
            written_lv[ch].push_back(lvl);
        end
        send_item(d);
    endtask

    task automatic send_score(input logic [31:0] word, input logic [7:0] er,
                              input logic [7:0] eg, input logic [7:0] eb, input logic last);
        t_in d;
        d             = random_fill();
        d.action      = ACT_SCORE;
        d.genome_word = word;
        d.env_red     = er;
        d.env_green   = eg;
        d.env_blue    = eb;
        d.last_word   = last;
        send_item(d);
    endtask

    function automatic logic [7:0] pick_level(input logic [1:0] ch);
        return written_lv[ch][$urandom_range(0, written_lv[ch].size() - 1)];
    endfunction

    // Stop offering, wait for every expected result, then let the pipeline
    // empty of items that produce none.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_scores.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic program_target(input logic [15:0] val);
        i_cfg_data <= val;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.target = val;
    endtask

    // One mask row set to the same value on all channels, then scored with its
    // complement: 96 bits per word, so ~683 words reach the saturation point.
    task automatic saturating_genome(input int n_words);
        logic [7:0]  lvl;
        logic [31:0] v;
        lvl = 8'($urandom_range(0, MaskLevels - 1));
        v   = $urandom;
        send_write(lvl, CH_RED, v, 1'b0);
        send_write(lvl, CH_GREEN, v, 1'b0);
        send_write(lvl, CH_BLUE, v, 1'b0);
        for (int k = 0; k < n_words; k++)
            send_score(~v, lvl, lvl, lvl, k == n_words - 1);
    endtask

    // Mostly genomes of 1-6 words with random content over written rows,
    // mixed with mask rewrites; a few genomes lose their last mark and run on
    // into the next one, and a few writes go to the unused column.
    task automatic random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          len;
        int          wsel;
        logic [31:0] w;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_write(8'($urandom_range(0, MaskLevels - 1)), CH_NONE, $urandom,
                           1'($urandom_range(0, 1)));
            end else if (pick < 36) begin
                send_write(8'($urandom_range(0, MaskLevels - 1)),
                           2'($urandom_range(CH_RED, CH_BLUE)),
                           $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    wsel = $urandom_range(0, 9);
                    w = (wsel == 0) ? 32'h0 : (wsel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
                    send_score(w, pick_level(CH_RED), pick_level(CH_GREEN),
                               pick_level(CH_BLUE), (k == len - 1) && (pick >= 40));
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] phase_target;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part, target at its reset value of zero ---
        // all-zero masks on the lowest row, all-one masks on the highest
        send_write(8'd0, CH_RED, 32'h0, 1'b0);
        send_write(8'd0, CH_GREEN, 32'h0, 1'b0);
        send_write(8'd0, CH_BLUE, 32'h0, 1'b0);
        send_write(8'd255, CH_RED, 32'hFFFF_FFFF, 1'b0);
        send_write(8'd255, CH_GREEN, 32'hFFFF_FFFF, 1'b0);
        send_write(8'd255, CH_BLUE, 32'hFFFF_FFFF, 1'b0);
        // unused column, last mark set: dropped, row 0 must stay zero
        send_write(8'd0, CH_NONE, 32'hFFFF_FFFF, 1'b1);
        send_score(32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0, 1'b1);     // 96
        send_score(32'h0, 8'd0, 8'd0, 8'd0, 1'b1);             // 0
        send_score(32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 1'b1);
        send_score(32'h0, 8'd255, 8'd255, 8'd255, 1'b1);
        // a write with the last mark mid-genome must neither emit nor clear
        send_score(32'hAAAA_5555, 8'd0, 8'd255, 8'd0, 1'b0);
        send_write(8'd255, CH_GREEN, 32'hFFFF_FFFF, 1'b1);
        send_score(32'hFFFF_0000, 8'd255, 8'd0, 8'd255, 1'b1);
        // a mid row with random masks, three-word genome
        send_write(8'd128, CH_RED, $urandom, 1'b0);
        send_write(8'd128, CH_GREEN, $urandom, 1'b0);
        send_write(8'd128, CH_BLUE, $urandom, 1'b0);
        send_score($urandom, 8'd128, 8'd128, 8'd128, 1'b0);
        send_score($urandom, 8'd128, 8'd128, 8'd128, 1'b0);
        send_score($urandom, 8'd128, 8'd128, 8'd128, 1'b1);
        wait_drained();

        // --- random phases, each under its own target ---
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       phase_target = 16'hFFFF;
                1:       phase_target = 16'h0000;
                3:       phase_target = 16'd150;
                5:       phase_target = 16'h5A5A;
                default: phase_target = 16'($urandom);
            endcase
            program_target(phase_target);
            quiet = (p == 5);
            if (p == 0) begin
                // results pile up behind a long receiver hold-off
                hold_req <= 1'b1;
                repeat (30)
                    send_score($urandom, pick_level(CH_RED), pick_level(CH_GREEN),
                               pick_level(CH_BLUE), 1'b1);
            end
            if (p == 1)
                saturating_genome(700);
            random_traffic(190);
            wait_drained();
        end

        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
